@@ rtl/core/mrh_pkg.sv @@
// Shared types, constants and the CRC-16 byte update for the Modbus RTU reply hunter.
`default_nettype none

package mrh_pkg;

   localparam logic [15:0] CrcInit      = 16'hFFFF;
   localparam logic [15:0] CrcPoly      = 16'hA001;
   localparam logic [7:0]  MaxDataBytes = 8'd251;
   localparam logic [7:0]  FuncReadRegs = 8'd3;
   localparam logic [7:0]  FuncWriteOne = 8'd6;
   localparam logic [7:0]  FuncWriteMany = 8'd16;
   localparam logic [7:0]  ExcBodyBytes = 8'd3;
   localparam logic [7:0]  WriteBodyBytes = 8'd6;
   localparam logic [7:0]  CrcBytes     = 8'd2;
   localparam int          CsrIndexWidth = 1;
   localparam int          CsrDataWidth  = 8;
   localparam int          RspDataWidth  = 48;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_STATION_ADDRESS   = 1'b0,
      CSR_EXPECTED_FUNCTION = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_DATA_WORD = 1'b0,
      KIND_STATUS    = 1'b1
   } result_kind_type;

   typedef enum logic [1:0] {
      STATUS_GOOD_NORMAL    = 2'd0,
      STATUS_GOOD_EXCEPTION = 2'd1,
      STATUS_CRC_MISMATCH   = 2'd2
   } frame_status_type;

   typedef struct packed {
      logic [7:0] station_address;
      logic [6:0] expected_function;
   } cfg_type;

   typedef struct packed {
      result_kind_type  result_kind;
      logic [15:0]      word_value;
      logic [6:0]       word_index;
      frame_status_type frame_status;
      logic [7:0]       exception_code;
      logic [8:0]       frame_length;
   } rsp_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_value,
                                              input logic [7:0] data);
      logic [15:0] c;
      c = crc_value ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/mrh_csr.sv @@
// Configuration registers of the Modbus RTU reply hunter: station address and function code.
`default_nettype none

module mrh_csr
   import mrh_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_data,
   output cfg_type                       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_STATION_ADDRESS:   cfg_in.station_address = csr_data;
            CSR_EXPECTED_FUNCTION: cfg_in.expected_function = csr_data[6:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.station_address   <= 8'd1;
         cfg_ff.expected_function <= 7'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/core/mrh_frame.sv @@
// Frame tracker of the Modbus RTU reply hunter: hunt, CRC check, word and status results.
`default_nettype none

module mrh_frame
   import mrh_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       in_valid,
   input  wire logic [7:0] in_byte,
   input  wire logic       out_ready,
   output logic            advance,
   output logic            rsp_valid,
   output rsp_type         rsp
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_FUNC,
      PH_COUNT,
      PH_BODY
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [8:0]  byte_position;
      logic [7:0]  bytes_remaining;
      logic [15:0] running_crc;
      logic        reply_is_exception;
      logic [7:0]  data_bytes_left;
      logic [7:0]  high_byte_hold;
      logic [6:0]  word_counter;
      logic [7:0]  held_exception_code;
   } frame_state_type;

   localparam frame_state_type HuntState = '{
      phase:               PH_HUNT,
      byte_position:       9'd0,
      bytes_remaining:     8'd0,
      running_crc:         CrcInit,
      reply_is_exception:  1'b0,
      data_bytes_left:     8'd0,
      high_byte_hold:      8'd0,
      word_counter:        7'd0,
      held_exception_code: 8'd0
   };

   frame_state_type state_ff;
   frame_state_type state_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_type         rsp_ff;
   rsp_type         rsp_in;
   logic [7:0]      exc_function;
   logic [7:0]      normal_function;
   logic [15:0]     crc_next;

   assign normal_function = {1'b0, cfg.expected_function};
   assign exc_function    = {1'b1, cfg.expected_function};
   assign crc_next        = crc16_byte(state_ff.running_crc, in_byte);
   assign advance         = in_valid && (!rsp_valid_ff || out_ready);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      unique case (state_ff.phase)
         PH_HUNT: begin
            if (in_byte == cfg.station_address) begin
               state_in               = HuntState;
               state_in.phase         = PH_FUNC;
               state_in.byte_position = 9'd1;
               state_in.running_crc   = crc16_byte(CrcInit, in_byte);
            end
         end
         PH_FUNC: begin
            if (in_byte == normal_function || in_byte == exc_function) begin
               state_in.running_crc   = crc_next;
               state_in.byte_position = 9'd2;
               state_in.phase         = PH_BODY;
               if (in_byte == exc_function) begin
                  state_in.reply_is_exception = 1'b1;
                  state_in.bytes_remaining    = ExcBodyBytes;
               end else if (in_byte == FuncWriteOne || in_byte == FuncWriteMany) begin
                  state_in.bytes_remaining = WriteBodyBytes;
               end else if (in_byte == FuncReadRegs) begin
                  state_in.phase = PH_COUNT;
               end else begin
                  state_in = HuntState;
               end
            end else begin
               state_in = HuntState;
               if (in_byte == cfg.station_address) begin
                  state_in.phase         = PH_FUNC;
                  state_in.byte_position = 9'd1;
                  state_in.running_crc   = crc16_byte(CrcInit, in_byte);
               end
            end
         end
         PH_COUNT: begin
            if (in_byte > MaxDataBytes) begin
               state_in = HuntState;
            end else begin
               state_in.running_crc     = crc_next;
               state_in.data_bytes_left = in_byte;
               state_in.bytes_remaining = in_byte + CrcBytes;
               state_in.byte_position   = 9'd3;
               state_in.phase           = PH_BODY;
            end
         end
         PH_BODY: begin
            state_in.running_crc = crc_next;
            if (state_ff.reply_is_exception && state_ff.byte_position == 9'd2) begin
               state_in.held_exception_code = in_byte;
            end
            if (state_ff.data_bytes_left != 8'd0) begin
               state_in.data_bytes_left = state_ff.data_bytes_left - 8'd1;
               if (state_ff.byte_position[0]) begin
                  state_in.high_byte_hold = in_byte;
               end else begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.result_kind    = KIND_DATA_WORD;
                  rsp_in.word_value     = {state_ff.high_byte_hold, in_byte};
                  rsp_in.word_index     = state_ff.word_counter;
                  state_in.word_counter = state_ff.word_counter + 7'd1;
               end
            end
            state_in.byte_position   = state_ff.byte_position + 9'd1;
            state_in.bytes_remaining = state_ff.bytes_remaining - 8'd1;
            if (state_ff.bytes_remaining == 8'd1) begin
               rsp_valid_in       = 1'b1;
               rsp_in             = '0;
               rsp_in.result_kind = KIND_STATUS;
               if (crc_next != 16'd0) begin
                  rsp_in.frame_status = STATUS_CRC_MISMATCH;
               end else if (state_ff.reply_is_exception) begin
                  rsp_in.frame_status = STATUS_GOOD_EXCEPTION;
               end else begin
                  rsp_in.frame_status = STATUS_GOOD_NORMAL;
               end
               rsp_in.exception_code = state_ff.reply_is_exception ?
                                       state_in.held_exception_code : 8'd0;
               rsp_in.frame_length   = state_ff.byte_position + 9'd1;
               state_in              = HuntState;
            end
         end
         default: state_in = HuntState;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= HuntState;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
      end else if (out_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef SYNTHESIS
   a_status_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.result_kind == KIND_STATUS) |-> rsp_ff.frame_length >= 9'd5)
      else $error("status beat carries a frame shorter than any legal reply");

   a_hunt_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_HUNT) |->
      (state_ff.byte_position == 9'd0 && state_ff.running_crc == CrcInit))
      else $error("hunt phase entered with leftover frame state");

   a_body_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_BODY) |->
      (state_ff.bytes_remaining != 8'd0 && state_ff.byte_position >= 9'd2))
      else $error("frame body tracked with no bytes left to collect");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !out_ready) |=> $stable(state_ff))
      else $error("frame state moved while the result beat was stalled");
`endif

endmodule

`default_nettype wire

@@ rtl/core/modbus_rtu_reply_hunter_unit.sv @@
// Top level of the Modbus RTU reply hunter: input stage, configuration and result packing.
`default_nettype none

// The unit takes one received serial byte per beat and can accept a new byte in every
// clock cycle while no result waits on rsp_tready, since the whole byte-wide CRC-16
// update and frame tracking are combinational between the input register and the
// result register. A byte's result beat, if it causes one, enters the result register
// as the frame stage takes the byte from the input register; a result waiting on
// rsp_tready holds the frame stage, and the input register then takes at most one more
// byte before req_tready drops. Data words of a function 3 reply come out as they
// complete; every finished frame ends with one status beat, which flags a CRC mismatch;
// frames with a malformed header are dropped silently; the station address hunt resumes.
module modbus_rtu_reply_hunter_unit
   import mrh_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // Configuration write channel.
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_data,
   // Received bytes.
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [7:0]               req_tdata,   // rx_byte[7:0]
   // Results.
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // word_value[15:0], word_index[22:16], frame_status[24:23],
   // exception_code[32:25], frame_length[41:33], zero[47:42]
   output logic [RspDataWidth-1:0]       rsp_tdata,
   output logic                          rsp_tuser    // result_kind[0]
);

   cfg_type    cfg;
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       advance;
   logic       rsp_valid;
   rsp_type    rsp;

   mrh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   mrh_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (in_valid_ff),
      .in_byte   (in_byte_ff),
      .out_ready (rsp_tready),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_tvalid = rsp_valid;
   assign rsp_tuser  = rsp.result_kind;
   assign rsp_tdata  = {6'd0, rsp.frame_length, rsp.exception_code, rsp.frame_status,
                        rsp.word_index, rsp.word_value};

endmodule

`default_nettype wire

@@ tb/modbus_rtu_reply_hunter_unit_tb.sv @@
// Self-checking testbench for the Modbus RTU reply hunter, with a byte-level frame predictor.
`timescale 1ns / 1ps

module modbus_rtu_reply_hunter_unit_tb;
   import mrh_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 300000;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned RANDOM_BYTES = 105;

   // Follows the hunt byte by byte and queues the result beats each byte should cause.
   class frame_tracker;
      logic [7:0]  station;
      logic [6:0]  function_code;
      logic [8:0]  position;
      logic [8:0]  remaining;
      logic [15:0] crc;
      logic        exception_reply;
      logic [7:0]  function_seen;
      logic [7:0]  data_left;
      logic [7:0]  high_hold;
      logic [6:0]  word_count;
      logic [7:0]  exception_held;
      rsp_type     pending_results[$];
      int unsigned beats_checked;
      int unsigned words_seen;
      int unsigned bad_beats;
      int unsigned status_seen[3];

      function new();
         station = 8'd1;
         function_code = 7'd3;
         beats_checked = 0;
         words_seen = 0;
         bad_beats = 0;
         status_seen = '{0, 0, 0};
         restart();
      endfunction

      static function logic [15:0] crc_step(input logic [15:0] value, input logic [7:0] b);
         logic [15:0] c;
         c = value ^ {8'h00, b};
         repeat (8) c = {1'b0, c[15:1]} ^ (c[0] ? CrcPoly : 16'h0000);
         return c;
      endfunction

      function void restart();
         position = '0;
         remaining = '0;
         crc = CrcInit;
         exception_reply = 1'b0;
         function_seen = '0;
         data_left = '0;
         high_hold = '0;
         word_count = '0;
         exception_held = '0;
      endfunction

      function void open_frame(input logic [7:0] b);
         restart();
         crc = crc_step(CrcInit, b);
         position = 9'd1;
      endfunction

      function void set_register(input csr_index_type idx, input logic [7:0] value);
         case (idx)
            CSR_STATION_ADDRESS: station = value;
            CSR_EXPECTED_FUNCTION: function_code = value[6:0];
            default: ;
         endcase
      endfunction

      function void take_byte(input logic [7:0] b);
         rsp_type r;
         logic    word_ready;
         r = '0;
         word_ready = 1'b0;
         if (position == 9'd0) begin
            if (b == station) open_frame(b);
            return;
         end
         if (position == 9'd1) begin
            if (b == {1'b0, function_code} || b == {1'b1, function_code}) begin
               crc = crc_step(crc, b);
               function_seen = b;
               position = 9'd2;
               if (b[7]) begin
                  exception_reply = 1'b1;
                  remaining = 9'(ExcBodyBytes);
               end else if (b == FuncWriteOne || b == FuncWriteMany) begin
                  remaining = 9'(WriteBodyBytes);
               end else if (b == FuncReadRegs) begin
                  remaining = '0;
               end else begin
                  restart();
               end
            end else begin
               restart();
               if (b == station) open_frame(b);
            end
            return;
         end
         if (function_seen == FuncReadRegs && !exception_reply && position == 9'd2) begin
            if (b > MaxDataBytes) begin
               restart();
               return;
            end
            crc = crc_step(crc, b);
            data_left = b;
            remaining = {1'b0, b} + 9'd2;
            position = 9'd3;
            return;
         end
         crc = crc_step(crc, b);
         if (exception_reply && position == 9'd2) exception_held = b;
         if (function_seen == FuncReadRegs && !exception_reply && data_left != 0) begin
            data_left--;
            if (position[0]) begin
               high_hold = b;
            end else begin
               r.word_value = {high_hold, b};
               r.word_index = word_count;
               word_count++;
               word_ready = 1'b1;
            end
         end
         position++;
         if (remaining != 0) remaining--;
         if (remaining == 0) begin
            r = '0;
            r.result_kind = KIND_STATUS;
            if (crc != 16'h0000) r.frame_status = STATUS_CRC_MISMATCH;
            else if (exception_reply) r.frame_status = STATUS_GOOD_EXCEPTION;
            else r.frame_status = STATUS_GOOD_NORMAL;
            r.exception_code = exception_reply ? exception_held : 8'h00;
            r.frame_length = position;
            pending_results.push_back(r);
            restart();
            return;
         end
         if (word_ready) begin
            r.result_kind = KIND_DATA_WORD;
            pending_results.push_back(r);
         end
      endfunction

      function void check_beat(input logic [RspDataWidth-1:0] data, input logic kind);
         rsp_type     want;
         logic [41:0] want_bits;
         if (pending_results.size() == 0) begin
            bad_beats++;
            if (bad_beats <= 10)
               $display("Result beat with nothing expected: kind %0d data %h", kind, data);
            return;
         end
         want = pending_results.pop_front();
         want_bits = {want.frame_length, want.exception_code, want.frame_status,
                      want.word_index, want.word_value};
         beats_checked++;
         if (kind !== want.result_kind || data[41:0] !== want_bits) begin
            bad_beats++;
            if (bad_beats <= 10) begin
               $write("Mismatch on beat %0d (expected/actual): kind %0d/%0d word %h/%h ",
                      beats_checked, want.result_kind, kind, want.word_value, data[15:0]);
               $display("index %0d/%0d status %0d/%0d exception %h/%h length %0d/%0d",
                        want.word_index, data[22:16], want.frame_status, data[24:23],
                        want.exception_code, data[32:25], want.frame_length, data[41:33]);
            end
         end else if (want.result_kind == KIND_STATUS) begin
            status_seen[want.frame_status]++;
         end else begin
            words_seen++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_data;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [7:0]               req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic                     rsp_tuser;

   frame_tracker tracker;
   logic [7:0]   frame_bytes[$];
   int           frame_start = 0;
   int unsigned  burst_left = 0;
   int unsigned  hold_requests = 0;
   int unsigned  bytes_sent = 0;
   int unsigned  frame_bytes_sent = 0;
   int unsigned  frames_sent = 0;
   int unsigned  cycle_count = 0;

   modbus_rtu_reply_hunter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
                  tracker.pending_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_byte(input logic [7:0] value);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 5);
         burst_left = $urandom_range(1, 32);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= value;
      do @(posedge clock); while (!req_tready);
      tracker.take_byte(value);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.set_register(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic void seal_frame();
      logic [15:0] c;
      c = CrcInit;
      for (int i = frame_start; i < frame_bytes.size(); i++)
         c = frame_tracker::crc_step(c, frame_bytes[i]);
      frame_bytes.push_back(c[7:0]);
      frame_bytes.push_back(c[15:8]);
   endfunction

   function automatic void build_normal(input logic [7:0] st, input logic [6:0] fn,
                                        input int count);
      frame_bytes.push_back(st);
      frame_bytes.push_back({1'b0, fn});
      if ({1'b0, fn} == FuncReadRegs) begin
         frame_bytes.push_back(8'(count));
         repeat (count) frame_bytes.push_back(8'($urandom));
      end else if ({1'b0, fn} == FuncWriteOne || {1'b0, fn} == FuncWriteMany) begin
         repeat (4) frame_bytes.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom));
      end
      seal_frame();
   endfunction

   function automatic void build_exception(input logic [7:0] st, input logic [6:0] fn,
                                           input logic [7:0] code);
      frame_bytes.push_back(st);
      frame_bytes.push_back({1'b1, fn});
      frame_bytes.push_back(code);
      seal_frame();
   endfunction

   function automatic void damage_frame();
      int idx;
      idx = $urandom_range(frame_start + 2, frame_bytes.size() - 1);
      frame_bytes[idx] = frame_bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
   endfunction

   task automatic ship_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
      frames_sent++;
      frame_bytes_sent += frame_bytes.size();
      frame_bytes = {};
      frame_start = 0;
   endtask

   task automatic send_random_frame();
      int         pick;
      int         count;
      logic [7:0] st;
      logic [7:0] wrong;
      logic [6:0] fn;
      st = tracker.station;
      fn = tracker.function_code;
      pick = $urandom_range(0, 99);
      count = ($urandom_range(0, 99) < 3) ? $urandom_range(240, 251) : $urandom_range(0, 12);
      if (pick < 10) begin
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
         return;
      end
      if (pick < 20) begin
         frame_bytes.push_back(st);
         frame_start = 1;
         if ($urandom_range(0, 1) != 0) begin
            wrong = 8'($urandom);
            if (wrong == {1'b0, fn} || wrong == {1'b1, fn}) wrong = {1'b0, fn} ^ 8'h40;
            frame_bytes.push_back(wrong);
            frame_start = 2;
         end
      end else if (pick < 26 && {1'b0, fn} == FuncReadRegs) begin
         frame_bytes.push_back(st);
         frame_bytes.push_back(FuncReadRegs);
         frame_bytes.push_back(8'($urandom_range(MaxDataBytes + 1, 255)));
         frame_start = 3;
      end
      if (pick >= 26 && pick < 42) build_exception(st, fn, 8'($urandom));
      else build_normal(st, fn, count);
      if ($urandom_range(0, 99) < 12) damage_frame();
      if ($urandom_range(0, 99) < 4) repeat ($urandom_range(1, 2)) void'(frame_bytes.pop_back());
      ship_frame();
   endtask

   task automatic apply_settings(input int phase);
      logic [7:0] st;
      logic [6:0] fn;
      st = 8'($urandom);
      case ($urandom_range(0, 5))
         0: fn = 7'(FuncWriteOne);
         1: fn = 7'(FuncWriteMany);
         2: fn = 7'($urandom_range(1, 127));
         default: fn = 7'(FuncReadRegs);
      endcase
      case (phase)
         0: begin st = 8'h00; fn = 7'(FuncReadRegs); end
         1: begin st = 8'hFF; fn = 7'(FuncReadRegs); end
         2: begin st = 8'h11; fn = 7'(FuncWriteOne); end
         3: begin st = 8'h2A; fn = 7'(FuncWriteMany); end
         4: begin st = 8'hF7; fn = 7'd127; end
         5: begin st = 8'h05; fn = 7'd1; end
         6: begin st = 8'h80; fn = 7'(FuncReadRegs); end
         default: ;
      endcase
      write_register(CSR_STATION_ADDRESS, st);
      write_register(CSR_EXPECTED_FUNCTION, {1'b0, fn});
   endtask

   initial begin : result_sink
      int unsigned sink_cycles;
      int unsigned hold_left;
      int unsigned holds_served;
      sink_cycles = 0;
      hold_left = 0;
      holds_served = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         sink_cycles++;
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case ((sink_cycles / 97) % 4)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (sink_cycles % 7) < 3;
               default: rsp_tready <= $urandom_range(0, 9) != 0;
            endcase
         end
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) tracker.check_beat(rsp_tdata, rsp_tuser);
      end
   end

   initial begin : stimulus
      int          phase;
      int unsigned phase_end;
      int unsigned failures;
      tracker = new();
      reset <= 1'b1;
      csr_valid <= 1'b0;
      csr_index <= CSR_STATION_ADDRESS;
      csr_data <= '0;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed frames under the reset settings, station 1 and function 3.
      frame_bytes = {8'h01, FuncReadRegs, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00};
      seal_frame();
      ship_frame();
      frame_bytes = {8'h01, FuncReadRegs, 8'h00};
      seal_frame();
      ship_frame();
      frame_bytes = {8'h01, FuncReadRegs, 8'h03, 8'h12, 8'h34, 8'h56};
      seal_frame();
      ship_frame();
      build_exception(8'h01, 7'(FuncReadRegs), 8'h00);
      ship_frame();
      build_exception(8'h01, 7'(FuncReadRegs), 8'hFF);
      frame_bytes[3] = frame_bytes[3] ^ 8'h80;
      ship_frame();
      frame_bytes = {8'h01, FuncReadRegs, 8'h02, 8'hA5, 8'h5A};
      seal_frame();
      frame_bytes[5] = frame_bytes[5] ^ 8'h01;
      ship_frame();
      // A second byte that is the station address starts a new frame.
      frame_bytes = {8'h01, 8'h01, FuncReadRegs, 8'h02, 8'h80, 8'h01};
      frame_start = 1;
      seal_frame();
      ship_frame();
      frame_bytes = {8'h01, 8'h07, 8'h01, FuncReadRegs, 8'h00};
      frame_start = 2;
      seal_frame();
      ship_frame();
      frame_bytes = {8'h01, FuncReadRegs, 8'hFC, 8'h01, FuncReadRegs, 8'h02, 8'h00, 8'h01};
      frame_start = 3;
      seal_frame();
      ship_frame();
      frame_bytes = {8'h00, 8'hFF, 8'h02, 8'h01, FuncReadRegs, 8'hFF,
                     8'h01, FuncReadRegs, 8'h02, 8'h7E, 8'hE7};
      frame_start = 6;
      seal_frame();
      ship_frame();
      drain_results();

      phase = 0;
      while (frame_bytes_sent < RANDOM_BYTES) begin
         apply_settings(phase);
         phase_end = frame_bytes_sent + 15;
         while (frame_bytes_sent < phase_end) send_random_frame();
         drain_results();
         phase++;
      end

      // Long output hold-off while read replies keep coming in.
      write_register(CSR_STATION_ADDRESS, 8'h5C);
      write_register(CSR_EXPECTED_FUNCTION, FuncReadRegs);
      hold_requests++;
      build_normal(8'h5C, 7'(FuncReadRegs), MaxDataBytes);
      ship_frame();
      build_normal(8'h5C, 7'(FuncReadRegs), 20);
      ship_frame();
      drain_results();

      failures = tracker.bad_beats + tracker.pending_results.size();
      if (tracker.pending_results.size() != 0)
         $display("%0d expected results never arrived.", tracker.pending_results.size());
      $display("Sent %0d bytes in %0d frames across %0d settings plus a long output hold-off.",
               bytes_sent, frames_sent, phase + 2);
      $display("Checked %0d data words and %0d good, %0d exception and %0d bad-CRC statuses.",
               tracker.words_seen, tracker.status_seen[0], tracker.status_seen[1],
               tracker.status_seen[2]);
      if (failures == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

@@ modbus_rtu_reply_hunter_unit.f @@
rtl/core/mrh_pkg.sv
rtl/core/mrh_csr.sv
rtl/core/mrh_frame.sv
rtl/core/modbus_rtu_reply_hunter_unit.sv
tb/modbus_rtu_reply_hunter_unit_tb.sv
